### rtl/core/mpka_pkg.sv
// ----------------------------------------------------------------------------
// mpka_pkg: shared types and constants for the pad key autorepeat block
// Field widths, configuration register indexes, reset values, config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mpka_pkg;

    localparam int WORD_W     = 16;
    localparam int TIMER_W    = 6;
    localparam int TYPE_W     = 4;
    localparam int OFFSET_W   = 4;
    localparam int INPUT_PADS = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TYPE_W-1:0] HANDLED_TYPE = 4'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd3;

    localparam logic [TIMER_W-1:0] INIT_DELAY_RST = 6'd32;
    localparam logic [TIMER_W-1:0] REP_PERIOD_RST = 6'd12;
    localparam logic [TIMER_W-1:0] MIN_PERIOD_RST = 6'd5;

    typedef struct packed {
        logic               accel_en;
        logic [TIMER_W-1:0] init_delay;
        logic [TIMER_W-1:0] rep_period;
        logic [TIMER_W-1:0] min_period;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/core/multi_pad_key_autorepeat.sv
// ----------------------------------------------------------------------------
// multi_pad_key_autorepeat: typematic autorepeat for several game pads
// Input register, per-pad update and pick, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a frame item (req_type 0)
//   with five held words and the pad type nibbles, or a consume item
//   (req_type 1). A frame item updates each handled pad and gives no result.
//   A consume item gives one result on o_out_valid / i_out_ready: the first
//   queued word in pad order (cleared as it is taken) and its byte offset.
//   A consume result is registered together with the pad update.
//   Throughput: one item per cycle unless a consume stalls, set by the
//   single update stage between the input register and the pad registers.
//   A stalled receiver holds the result register; frame items keep flowing,
//   a consume item waits in the input register until the result is taken.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) is to be written
//   by the user only while the block is idle; the block does not enforce it.
//   Reset clears all pad state, empties both registers and restores the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pad_key_autorepeat #(
    parameter int PADS = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mpka_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mpka_pkg::TIMER_W-1:0]     i_cfg_data,
    // input items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_req_type,
    input  wire logic [mpka_pkg::WORD_W-1:0]      i_held_0,
    input  wire logic [mpka_pkg::WORD_W-1:0]      i_held_1,
    input  wire logic [mpka_pkg::WORD_W-1:0]      i_held_2,
    input  wire logic [mpka_pkg::WORD_W-1:0]      i_held_3,
    input  wire logic [mpka_pkg::WORD_W-1:0]      i_held_4,
    input  wire logic [19:0]                      i_pad_types,
    // result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [mpka_pkg::WORD_W-1:0]      o_key_word,
    output logic      [mpka_pkg::OFFSET_W-1:0]    o_slot_offset
);

    localparam int IDX_W = (PADS > 1) ? $clog2(PADS) : 1;

    mpka_pkg::t_cfg r_cfg;

    logic                          r_in_vld;
    logic                          r_req_type;
    logic [mpka_pkg::WORD_W-1:0]   r_held [mpka_pkg::INPUT_PADS];
    logic [19:0]                   r_types;

    logic                          r_out_vld;
    logic [mpka_pkg::WORD_W-1:0]   r_key_word;
    logic [mpka_pkg::OFFSET_W-1:0] r_slot_offset;

    logic                          advance;
    logic                          scan;
    logic                          take;
    logic                          out_free;
    logic [mpka_pkg::WORD_W-1:0]   queued [PADS];
    logic [IDX_W-1:0]              sel;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_en   <= 1'b0;
            r_cfg.init_delay <= mpka_pkg::INIT_DELAY_RST;
            r_cfg.rep_period <= mpka_pkg::REP_PERIOD_RST;
            r_cfg.min_period <= mpka_pkg::MIN_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mpka_pkg::CFG_ACCEL_EN:   r_cfg.accel_en   <= i_cfg_data[0];
                mpka_pkg::CFG_INIT_DELAY: r_cfg.init_delay <= i_cfg_data;
                mpka_pkg::CFG_REP_PERIOD: r_cfg.rep_period <= i_cfg_data;
                mpka_pkg::CFG_MIN_PERIOD: r_cfg.min_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: a frame item always advances, a consume needs the result slot
    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && (!r_req_type || out_free);
    assign scan       = advance && !r_req_type;
    assign take       = advance && r_req_type;
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req_type <= i_req_type;
            r_held[0]  <= i_held_0;
            r_held[1]  <= i_held_1;
            r_held[2]  <= i_held_2;
            r_held[3]  <= i_held_3;
            r_held[4]  <= i_held_4;
            r_types    <= i_pad_types;
        end
    end

    // per-pad state
    for (genvar p = 0; p < PADS; p++) begin : g_pad
        logic [mpka_pkg::WORD_W-1:0] held;
        logic                        handled;
        logic                        clear;

        if (p < mpka_pkg::INPUT_PADS) begin : g_live
            assign held    = r_held[p];
            assign handled = r_types[mpka_pkg::TYPE_W*p +: mpka_pkg::TYPE_W]
                             == mpka_pkg::HANDLED_TYPE;
        end else begin : g_idle
            assign held    = '0;
            assign handled = 1'b0;
        end

        assign clear = take && (sel == IDX_W'(p));

        mpka_pad u_pad (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_scan    (scan),
            .i_clear   (clear),
            .i_handled (handled),
            .i_held    (held),
            .i_cfg     (r_cfg),
            .o_queued  (queued[p])
        );
    end

    // first queued pad wins, the last pad when none is queued
    always_comb begin
        sel = IDX_W'(PADS - 1);
        for (int p = PADS - 2; p >= 0; p--) begin
            if (queued[p] != '0) begin
                sel = IDX_W'(p);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key_word    <= queued[sel];
            r_slot_offset <= mpka_pkg::OFFSET_W'({sel, 1'b0});
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_key_word    = r_key_word;
    assign o_slot_offset = r_slot_offset;

endmodule

`default_nettype wire

### rtl/core/mpka_pad.sv
// ----------------------------------------------------------------------------
// mpka_pad: autorepeat state of one pad
// Holds last word, queued word, frame timer, period and fast mark, and
// updates them on a frame scan or clears the queued word on a consume.
// ----------------------------------------------------------------------------
`default_nettype none

module mpka_pad (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_scan,
    input  wire logic                           i_clear,
    input  wire logic                           i_handled,
    input  wire logic [mpka_pkg::WORD_W-1:0]    i_held,
    input  wire mpka_pkg::t_cfg                 i_cfg,
    output logic      [mpka_pkg::WORD_W-1:0]    o_queued
);

    logic [mpka_pkg::WORD_W-1:0]  r_last,   n_last;
    logic [mpka_pkg::WORD_W-1:0]  r_queued, n_queued;
    logic [mpka_pkg::TIMER_W-1:0] r_frames, n_frames;
    logic [mpka_pkg::TIMER_W-1:0] r_period, n_period;
    logic                         r_fast,   n_fast;
    logic [mpka_pkg::TIMER_W-1:0] per_dec;
    logic                         below_min;

    always_comb begin
        // decrement saturating at zero, then floor under acceleration
        per_dec   = (r_period != '0) ? r_period - 1'b1 : r_period;
        below_min = per_dec < i_cfg.min_period;
    end

    always_comb begin
        n_last   = r_last;
        n_queued = r_queued;
        n_frames = r_frames;
        n_period = r_period;
        n_fast   = r_fast;
        if (i_clear) begin
            n_queued = '0;
        end else if (i_scan && i_handled) begin
            priority if (i_held == '0) begin
                n_last = '0;
                n_fast = 1'b0;
            end else if (i_held != r_last) begin
                n_last   = i_held;
                n_queued = i_held;
                n_frames = i_cfg.init_delay;
                n_period = i_cfg.rep_period;
            end else if (r_frames > mpka_pkg::TIMER_W'(1)) begin
                n_frames = r_frames - 1'b1;
            end else if (r_frames == mpka_pkg::TIMER_W'(1)) begin
                n_queued = r_last;
                if (i_cfg.accel_en) begin
                    if (below_min) begin
                        n_period = i_cfg.min_period;
                        n_frames = i_cfg.min_period;
                        n_fast   = 1'b1;
                    end else begin
                        n_period = per_dec;
                        n_frames = per_dec;
                    end
                end else begin
                    n_frames = r_period;
                end
            end else begin
                // timer already run out: drop the word and restart
                n_queued = '0;
                n_frames = i_cfg.init_delay;
                n_period = i_cfg.rep_period;
                n_last   = '0;
                n_fast   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_queued <= '0;
            r_frames <= '0;
            r_period <= '0;
            r_fast   <= 1'b0;
        end else begin
            r_last   <= n_last;
            r_queued <= n_queued;
            r_frames <= n_frames;
            r_period <= n_period;
            r_fast   <= n_fast;
        end
    end

    assign o_queued = r_queued;

endmodule

`default_nettype wire

### rtl/core/mpka_checker.sv
// ----------------------------------------------------------------------------
// mpka_checker: port-level checks for the pad key autorepeat block
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module mpka_checker #(
    parameter int PADS = 5
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [mpka_pkg::WORD_W-1:0]    o_key_word,
    input wire logic [mpka_pkg::OFFSET_W-1:0]  o_slot_offset
);

    localparam logic [mpka_pkg::OFFSET_W-1:0] LAST_OFFSET =
        mpka_pkg::OFFSET_W'(2 * (PADS - 1));

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_word)
            && $stable(o_slot_offset))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // with the result slot empty nothing can block the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result slot");

    a_even_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_slot_offset[0])
        else $error("odd slot offset");

    a_empty_pick_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_key_word == '0) |-> o_slot_offset == LAST_OFFSET)
        else $error("empty consume did not pick the last pad");

endmodule

bind multi_pad_key_autorepeat mpka_checker #(.PADS(PADS)) u_mpka_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_key_word    (o_key_word),
    .o_slot_offset (o_slot_offset)
);

`default_nettype wire
